>>> sv/jsu_pkg.sv
// Package for the JSON string unescaper: phase codes, result codes,
// the result-group record passed from front to back, and the hex digit decode.
// No dependencies.
package jsu_pkg;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_STR  = 3'd1,
        PH_ESC  = 3'd2,
        PH_HEX0 = 3'd3,
        PH_HEX1 = 3'd4,
        PH_HEX2 = 3'd5,
        PH_HEX3 = 3'd6
    } t_phase;

    localparam logic [1:0] ST_BUSY = 2'd0;
    localparam logic [1:0] ST_DONE = 2'd1;
    localparam logic [1:0] ST_ERR  = 2'd2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;

    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;

    // group queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // all results caused by one input item
    typedef struct packed {
        logic [2:0][7:0] bytes;      // emission order, entry 0 first
        logic [1:0]      extra;      // number of results minus one
        logic            byte_valid;
        logic [1:0]      status;     // status of the final result
    } t_grp;

    // bit 4 set for a non-hex character
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            v = {1'b0, c[3:0] + 4'd9};
        return v;
    endfunction

endpackage

>>> sv/jsu_if.sv
// Handshake channels of the JSON string unescaper: input text bytes and
// decoded result items. Depends on nothing.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;
    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [1:0] status;
    logic       last;
    modport source (output valid, output out_byte, output byte_valid, output status,
                    output last, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input status,
                    input last, output ready);
endinterface

>>> sv/jsu_front.sv
// Front end: accepts text bytes, runs the string/escape/hex phase machine and
// turns each item into a result group. Depends on jsu_pkg, jsu_if.
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    jsu_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output jsu_pkg::t_grp o_grp
);
    import jsu_pkg::*;

    t_phase      r_phase, n_phase;
    logic [11:0] r_acc, n_acc;

    logic [7:0]  c;
    logic        eot;
    logic [4:0]  hv;
    logic        hex_ok;
    logic [15:0] code;

    assign c      = i_in.in_byte;
    assign eot    = i_in.text_end;
    assign hv     = hex_value(c);
    assign hex_ok = !eot && !hv[4];
    assign code   = {r_acc, hv[3:0]};

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_acc   <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        case (r_phase)
            PH_STR: begin
                if (eot) begin
                    n_phase = PH_IDLE;
                    n_acc   = '0;
                end else if (c == CH_BSL) n_phase = PH_ESC;
                else if (c == CH_QUOTE) n_phase = PH_IDLE;
            end
            PH_ESC: begin
                n_phase = PH_IDLE;
                n_acc   = '0;
                if (!eot) begin
                    case (c)
                        CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T:
                            n_phase = PH_STR;
                        CH_U: n_phase = PH_HEX0;
                        default: n_phase = PH_IDLE;
                    endcase
                end
            end
            PH_HEX0, PH_HEX1, PH_HEX2: begin
                if (hex_ok) begin
                    n_acc = {r_acc[7:0], hv[3:0]};
                    case (r_phase)
                        PH_HEX0: n_phase = PH_HEX1;
                        PH_HEX1: n_phase = PH_HEX2;
                        default: n_phase = PH_HEX3;
                    endcase
                end else begin
                    n_phase = PH_IDLE;
                    n_acc   = '0;
                end
            end
            PH_HEX3: begin
                n_acc   = '0;
                n_phase = hex_ok ? PH_STR : PH_IDLE;
            end
            default: begin
                // idle and the unused code both wait for an opening quote
                n_acc   = '0;
                n_phase = (!eot && c == CH_QUOTE) ? PH_STR : PH_IDLE;
            end
        endcase
    end

    // result group
    always_comb begin
        o_grp            = '0;
        o_grp.status     = ST_BUSY;
        case (r_phase)
            PH_STR: begin
                if (eot) o_grp.status = ST_ERR;
                else if (c == CH_QUOTE) o_grp.status = ST_DONE;
                else if (c != CH_BSL) begin
                    o_grp.bytes[0]   = c;
                    o_grp.byte_valid = 1'b1;
                end
            end
            PH_ESC: begin
                o_grp.byte_valid = 1'b1;
                case (c)
                    CH_QUOTE, CH_BSL, CH_SLASH: o_grp.bytes[0] = c;
                    CH_B: o_grp.bytes[0] = 8'h08;
                    CH_F: o_grp.bytes[0] = 8'h0C;
                    CH_N: o_grp.bytes[0] = 8'h0A;
                    CH_R: o_grp.bytes[0] = 8'h0D;
                    CH_T: o_grp.bytes[0] = 8'h09;
                    CH_U: o_grp.byte_valid = 1'b0;
                    default: begin
                        o_grp.byte_valid = 1'b0;
                        o_grp.status     = ST_ERR;
                    end
                endcase
                if (eot) begin
                    o_grp.bytes[0]   = '0;
                    o_grp.byte_valid = 1'b0;
                    o_grp.status     = ST_ERR;
                end
            end
            PH_HEX0, PH_HEX1, PH_HEX2: begin
                if (!hex_ok) o_grp.status = ST_ERR;
            end
            PH_HEX3: begin
                if (!hex_ok) o_grp.status = ST_ERR;
                else begin
                    o_grp.byte_valid = 1'b1;
                    if (code[15:7] == '0) begin
                        o_grp.bytes[0] = code[7:0];
                    end else if (code[15:11] == '0) begin
                        o_grp.extra    = 2'd1;
                        o_grp.bytes[0] = UTF_LEAD2 | {3'b000, code[10:6]};
                        o_grp.bytes[1] = UTF_CONT | {2'b00, code[5:0]};
                    end else begin
                        o_grp.extra    = 2'd2;
                        o_grp.bytes[0] = UTF_LEAD3 | {4'b0000, code[15:12]};
                        o_grp.bytes[1] = UTF_CONT | {2'b00, code[11:6]};
                        o_grp.bytes[2] = UTF_CONT | {2'b00, code[5:0]};
                    end
                end
            end
            default: begin
                if (eot || c != CH_QUOTE) o_grp.status = ST_ERR;
            end
        endcase
    end

endmodule

>>> sv/jsu_queue.sv
// Short group queue between front and back ends.
// Depends on jsu_pkg.
module jsu_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_grp i_grp,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output jsu_pkg::t_grp o_grp
);
    import jsu_pkg::*;

    t_grp            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [Q_AW:0]   r_cnt, n_cnt;
    logic            do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_grp   = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = i_push ? r_wp + 1'b1 : r_wp;
        n_rp  = do_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_grp;
    end

endmodule

>>> sv/jsu_back.sv
// Back end: unpacks each result group into one to three result items and
// holds them in an output register. Depends on jsu_pkg, jsu_if.
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  jsu_pkg::t_grp i_grp,
    output logic          o_pop,
    jsu_out_if.source     o_out
);
    import jsu_pkg::*;

    logic [1:0] r_sub, n_sub;
    logic       r_ovalid, n_ovalid;
    logic [7:0] r_obyte;
    logic       r_obv;
    logic [1:0] r_ost;
    logic       r_olast;

    logic       load;
    logic       take;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = !r_ovalid || o_out.ready;
    assign take    = load && i_q_valid;
    assign is_last = (r_sub == i_grp.extra);
    assign o_pop   = take && is_last;

    always_comb begin
        case (r_sub)
            2'd0:    sel_byte = i_grp.bytes[0];
            2'd1:    sel_byte = i_grp.bytes[1];
            default: sel_byte = i_grp.bytes[2];
        endcase
    end

    always_comb begin
        n_sub    = r_sub;
        n_ovalid = r_ovalid;
        if (load) n_ovalid = i_q_valid;
        if (take) n_sub = is_last ? 2'd0 : r_sub + 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_sub    <= n_sub;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_obyte <= sel_byte;
            r_obv   <= i_grp.byte_valid;
            r_ost   <= is_last ? i_grp.status : ST_BUSY;
            r_olast <= is_last;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.out_byte   = r_obyte;
    assign o_out.byte_valid = r_obv;
    assign o_out.status     = r_ost;
    assign o_out.last       = r_olast;

endmodule

>>> sv/json_string_unescape_utf8.sv
// Top level of the streaming JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_if, jsu_front, jsu_queue, jsu_back.
//
//   channel  dir  handshake          payload
//   i_in     in   valid / ready      in_byte[7:0], text_end
//   o_out    out  valid / ready      out_byte[7:0], byte_valid, status[1:0], last
//
// One input item per cycle while the queue has room; each item gives one result,
// or two or three for a \u escape decoding to a multi-byte UTF-8 sequence,
// one result per cycle while o_out is ready. Each result passes through the
// group queue and then the output register. A four-group queue sits between front
// and back, so input keeps flowing while results are stalled until the queue fills.
// Synchronous active-low reset returns the block to waiting for an opening quote.
module json_string_unescape_utf8 (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    logic q_full;
    logic push;
    t_grp push_grp;
    logic q_valid;
    t_grp head_grp;
    logic pop;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_grp    (push_grp)
    );

    jsu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_grp   (push_grp),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_grp   (head_grp)
    );

    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_grp     (head_grp),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

>>> sv/jsu_checker.sv
// Port-level checks on the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg, json_string_unescape_utf8.
module jsu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_byte_valid,
    input logic [1:0] i_out_status,
    input logic       i_out_last
);
    import jsu_pkg::*;

    // a stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
        $stable(i_out_status) && $stable(i_out_last))
        else $error("stalled result changed");

    // nothing is offered straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // an item without a byte carries a zero byte
    a_nobyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_byte_valid |-> i_out_byte == 8'h00)
        else $error("non-zero byte without byte_valid");

    // inner items of a UTF-8 sequence carry a byte and no final status
    a_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> i_out_byte_valid && i_out_status == ST_BUSY)
        else $error("bad inner result of multi-byte sequence");

    // an error never carries a byte and is the last item
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status == ST_ERR |-> !i_out_byte_valid && i_out_last)
        else $error("error result carries a byte");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_byte_valid (o_out.byte_valid),
    .i_out_status     (o_out.status),
    .i_out_last       (o_out.last)
);
